### rtl/tng_pkg.sv
package tng_pkg;

	// Operation codes of an input beat
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Separator placed between neighboring tokens of a composite
	localparam logic [7:0] JOIN_MARK = 8'h25;

	localparam int CHUNK_BYTES = 8;

	// One composite byte event from the sequencer to the chunk packer
	typedef struct packed {
		logic       valid;
		logic       has_byte;   // carries a byte (clear only for an empty composite)
		logic       from_mem;   // byte comes from the store, else the join mark
		logic       comp_end;   // last event of the composite
		logic       batch_end;  // last event caused by this end of token
		logic [1:0] order;
	} tng_ev_t;

endpackage

### rtl/tng_if.sv
interface tng_in_if;
	import tng_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface tng_out_if;
	import tng_pkg::*;

	logic        valid;
	logic        ready;
	logic [63:0] chunk;
	logic [3:0]  chunk_bytes;
	logic [1:0]  gram_order;
	logic        composite_end;
	logic        batch_end;

	modport source (output valid, output chunk, output chunk_bytes, output gram_order,
		output composite_end, output batch_end, input ready);
	modport sink   (input valid, input chunk, input chunk_bytes, input gram_order,
		input composite_end, input batch_end, output ready);
endinterface

### rtl/tng_store.sv
module tng_store #(
	parameter int DEPTH = 96,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data when no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/tng_seq.sv
module tng_seq #(
	parameter int HISTORY_DEPTH   = 3,
	parameter int TOKEN_MAX_BYTES = 32,
	parameter int AW              = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	tng_in_if.sink          items_in,
	input  logic            stall,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output logic [7:0]      wr_data,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	output tng_pkg::tng_ev_t ev_s1
);
	import tng_pkg::*;

	localparam int SW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int LW   = $clog2(TOKEN_MAX_BYTES + 1);
	localparam int BW   = $clog2(TOKEN_MAX_BYTES);
	localparam int MW   = AW + 1;
	localparam int SUMW = CW + 2;

	localparam logic PH_BYTE = 1'b0;
	localparam logic PH_MARK = 1'b1;

	logic          busy_q;
	logic          phase_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [BW-1:0] b_q;
	logic [SW-1:0] ws_q;
	logic [CW-1:0] held_q;
	logic [LW-1:0] fill_q;
	logic [LW-1:0] len_q [HISTORY_DEPTH];

	logic            accept;
	logic [SUMW-1:0] slot_sum;
	logic [SW-1:0]   slot;
	logic [LW-1:0]   tok_len;
	logic            tok_last, comp_last, len_zero, byte_last;
	logic            adv_tok, b_step, go_byte;
	tng_ev_t         ev;

	assign items_in.ready = !busy_q;
	assign accept         = items_in.valid && !busy_q;

	// Slot of token i in composite n, counted back from the write slot
	assign slot_sum = SUMW'(ws_q) + SUMW'(HISTORY_DEPTH) - SUMW'(n_q) + SUMW'(i_q);
	assign slot     = (slot_sum >= SUMW'(HISTORY_DEPTH)) ?
		SW'(slot_sum - SUMW'(HISTORY_DEPTH)) : SW'(slot_sum);
	assign tok_len  = len_q[slot];

	assign wr_en   = accept && (items_in.operation == OP_BYTE) &&
		(fill_q < LW'(TOKEN_MAX_BYTES));
	assign wr_addr = AW'(MW'(ws_q) * MW'(TOKEN_MAX_BYTES) + MW'(fill_q));
	assign wr_data = items_in.data_byte;

	assign rd_addr = AW'(MW'(slot) * MW'(TOKEN_MAX_BYTES) + MW'(b_q));
	assign rd_en   = busy_q && (phase_q == PH_BYTE) && !len_zero && !stall;

	always_comb begin
		ev        = '0;
		adv_tok   = 1'b0;
		b_step    = 1'b0;
		go_byte   = 1'b0;
		tok_last  = (i_q + CW'(1)) == n_q;
		comp_last = n_q == held_q;
		len_zero  = tok_len == '0;
		byte_last = (LW'(b_q) + LW'(1)) == tok_len;
		if (busy_q) begin
			case (phase_q)
				PH_MARK: begin
					ev.valid    = 1'b1;
					ev.has_byte = 1'b1;
					ev.comp_end = tok_last && len_zero;
					if (len_zero) begin
						adv_tok = 1'b1;
					end else begin
						go_byte = 1'b1;
					end
				end
				PH_BYTE: begin
					if (len_zero) begin
						// empty leading token: an event only for an empty composite
						ev.valid    = n_q == CW'(1);
						ev.comp_end = 1'b1;
						adv_tok     = 1'b1;
					end else begin
						ev.valid    = 1'b1;
						ev.has_byte = 1'b1;
						ev.from_mem = 1'b1;
						ev.comp_end = tok_last && byte_last;
						if (byte_last) begin
							adv_tok = 1'b1;
						end else begin
							b_step = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		ev.batch_end = ev.comp_end && comp_last;
		ev.order     = 2'(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_BYTE;
			n_q     <= '0;
			i_q     <= '0;
			b_q     <= '0;
			ws_q    <= '0;
			held_q  <= '0;
			fill_q  <= '0;
			ev_s1   <= '0;
		end else begin
			if (!stall) begin
				ev_s1 <= ev;
			end
			if (accept) begin
				case (items_in.operation)
					OP_BYTE: begin
						if (fill_q < LW'(TOKEN_MAX_BYTES)) begin
							fill_q <= fill_q + LW'(1);
						end
					end
					OP_END: begin
						fill_q  <= '0;
						ws_q    <= (ws_q == SW'(HISTORY_DEPTH - 1)) ? '0 : ws_q + SW'(1);
						if (held_q < CW'(HISTORY_DEPTH)) begin
							held_q <= held_q + CW'(1);
						end
						busy_q  <= 1'b1;
						n_q     <= CW'(1);
						i_q     <= '0;
						b_q     <= '0;
						phase_q <= PH_BYTE;
					end
					OP_CLEAR: begin
						held_q <= '0;
						fill_q <= '0;
					end
					default: ;
				endcase
			end else if (busy_q && !stall) begin
				if (go_byte) begin
					phase_q <= PH_BYTE;
					b_q     <= '0;
				end
				if (b_step) begin
					b_q <= b_q + BW'(1);
				end
				if (adv_tok) begin
					b_q <= '0;
					if (tok_last) begin
						if (comp_last) begin
							busy_q <= 1'b0;
						end else begin
							n_q     <= n_q + CW'(1);
							i_q     <= '0;
							phase_q <= PH_BYTE;
						end
					end else begin
						i_q     <= i_q + CW'(1);
						phase_q <= PH_MARK;
					end
				end
			end
		end
	end

	// Token lengths, written at the end of each token
	always_ff @(posedge clk) begin
		if (accept && items_in.operation == OP_END) begin
			len_q[ws_q] <= fill_q;
		end
	end

endmodule

### rtl/tng_pack.sv
module tng_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  tng_pkg::tng_ev_t ev_s1,
	input  logic [7:0]       rd_data,
	output logic             stall,
	tng_out_if.source        chunks_out
);
	import tng_pkg::*;

	logic [63:0] chunk_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	logic [63:0] out_chunk_q;
	logic [3:0]  out_bytes_q;
	logic [1:0]  out_order_q;
	logic        out_cend_q;
	logic        out_bend_q;

	logic [7:0]  byte_v;
	logic [63:0] next_chunk;
	logic [3:0]  next_cnt;
	logic        push, take;

	assign byte_v = ev_s1.from_mem ? rd_data : JOIN_MARK;

	always_comb begin
		next_chunk = chunk_q;
		next_cnt   = cnt_q;
		if (ev_s1.has_byte) begin
			next_chunk[{cnt_q[2:0], 3'b000} +: 8] = byte_v;
			next_cnt = cnt_q + 4'd1;
		end
	end

	assign push  = ev_s1.valid && (ev_s1.comp_end || next_cnt == 4'(CHUNK_BYTES));
	assign stall = push && out_valid_q && !chunks_out.ready;
	assign take  = ev_s1.valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (push) begin
					chunk_q <= '0;
					cnt_q   <= '0;
				end else begin
					chunk_q <= next_chunk;
					cnt_q   <= next_cnt;
				end
			end
			if (take && push) begin
				out_valid_q <= 1'b1;
			end else if (chunks_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && push) begin
			out_chunk_q <= next_chunk;
			out_bytes_q <= next_cnt;
			out_order_q <= ev_s1.order;
			out_cend_q  <= ev_s1.comp_end;
			out_bend_q  <= ev_s1.batch_end;
		end
	end

	assign chunks_out.valid         = out_valid_q;
	assign chunks_out.chunk         = out_chunk_q;
	assign chunks_out.chunk_bytes   = out_bytes_q;
	assign chunks_out.gram_order    = out_order_q;
	assign chunks_out.composite_end = out_cend_q;
	assign chunks_out.batch_end     = out_bend_q;

endmodule

### rtl/token_ngram_composer_top.sv
// Word n-gram composer. Token bytes enter one beat at a time (operation 0) and
// fill the slot of a ring that keeps the last HISTORY_DEPTH tokens; bytes past
// TOKEN_MAX_BYTES are dropped. An end-of-token beat (operation 1) stores the
// token and emits, for n = 1 up to the number of tokens held, one composite of
// the newest n tokens, oldest first, joined by '%'. Each composite goes out as
// chunks of up to eight bytes, first byte in bits 7:0, unused upper bytes zero,
// and always starts a fresh chunk; an empty one-token composite is a single
// chunk with chunk_bytes 0. composite_end marks the last chunk of a composite,
// batch_end the last chunk of the whole end-of-token batch. Operation 2 clears
// the history and the partial token; operation 3 is ignored. A byte, clear or
// ignored beat is taken whenever the input is ready. After an end-of-token beat
// the composites stream through the single read port of the byte store, one
// composite byte (token byte or join mark) per cycle while the output side does
// not stall, and the walk also visits each empty leading token; the input is
// not ready until the last byte has been read. One result register decouples
// the output.
module token_ngram_composer_top #(
	parameter int HISTORY_DEPTH   = 3,
	parameter int TOKEN_MAX_BYTES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tng_in_if.sink    items_in,
	tng_out_if.source chunks_out
);
	import tng_pkg::*;

	localparam int STORE_DEPTH = HISTORY_DEPTH * TOKEN_MAX_BYTES;
	localparam int AW          = $clog2(STORE_DEPTH);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          stall;
	tng_ev_t       ev_s1;

	// Byte store: one slot of TOKEN_MAX_BYTES bytes per history entry
	tng_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Take input beats, keep the ring bookkeeping, walk the composites
	tng_seq #(
		.HISTORY_DEPTH   (HISTORY_DEPTH),
		.TOKEN_MAX_BYTES (TOKEN_MAX_BYTES),
		.AW              (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.items_in (items_in),
		.stall    (stall),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.ev_s1    (ev_s1)
	);

	// Pack composite bytes into chunks; hold the walk while the output is full
	tng_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_s1      (ev_s1),
		.rd_data    (rd_data),
		.stall      (stall),
		.chunks_out (chunks_out)
	);

`ifndef SYNTHESIS
	// An end of token always starts a composite walk, so input drops ready
	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		items_in.valid && items_in.ready && items_in.operation == OP_END
		|=> !items_in.ready)
		else $error("input stayed ready after an end of token");

	// Only the one-token composite of an empty token may be empty
	a_empty_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		chunks_out.valid && chunks_out.chunk_bytes == 4'd0
		|-> chunks_out.composite_end && chunks_out.gram_order == 2'd1)
		else $error("empty chunk outside an empty one-token composite");

	// Never read the store while the walk is held; the held byte stays put
	a_no_read_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !rd_en ##1 $stable(rd_data))
		else $error("store read data moved during a stall");

	// Batch end only closes a composite, and no chunk exceeds eight bytes
	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		chunks_out.valid |-> (!chunks_out.batch_end || chunks_out.composite_end) &&
		chunks_out.chunk_bytes <= 4'd8)
		else $error("malformed chunk flags");
`endif

endmodule

### verif/token_ngram_composer_top_tb.sv
`timescale 1ns / 100ps

module token_ngram_composer_top_tb;
	import tng_pkg::*;

	// Operation 3 has no name in the package; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int DEPTH      = 3;
	localparam int MAX_BYTES  = 32;
	localparam int IDLE_LIMIT = 4000;   // cycles with no beat on either side
	localparam int PHASE_ITEMS = 14;

	// One output beat as the checker sees it
	typedef struct packed {
		logic [63:0] chunk;
		logic [3:0]  nbytes;
		logic [1:0]  order;
		logic        comp_end;
		logic        batch_end;
	} chunk_beat_t;

	// One row of the directed script: a beat repeated reps times, the byte
	// advancing by step each time. Rows with pin set carry the single chunk
	// that they must produce, typed in by hand.
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [7:0]  reps;
		logic [7:0]  step;
		logic        pin;
		chunk_beat_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tng_in_if  items_if ();
	tng_out_if chunks_if ();

	token_ngram_composer_top #(
		.HISTORY_DEPTH  (DEPTH),
		.TOKEN_MAX_BYTES(MAX_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items_in  (items_if),
		.chunks_out(chunks_if)
	);

	// Shingle predictor state: ring of token bytes and lengths
	logic [7:0]  hist_bytes [DEPTH][MAX_BYTES];
	logic [5:0]  hist_len [DEPTH];
	int unsigned slot_w;
	int unsigned held;
	int unsigned fill;

	chunk_beat_t expected_chunks [$];
	int          failures  = 0;
	int          idle_pct  = 0;
	int          stall_pct = 0;

	stim_row_t script [23] = '{
		// empty token straight after reset: one zero-length chunk
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b1, '{64'h0, 4'd0, 2'd1, 1'b1, 1'b1}},
		'{OP_CLEAR,  8'h5A, 8'd1,  8'd0,  1'b0, '0},
		'{OP_BYTE,   8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_BYTE,   8'hFF, 8'd1,  8'd0,  1'b0, '0},
		// history was cleared, so only the one-token composite comes out
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b1, '{64'hFF00, 4'd2, 2'd1, 1'b1, 1'b1}},
		'{OP_UNUSED, 8'hAA, 8'd1,  8'd0,  1'b0, '0},
		// overlong token: the last three bytes must be dropped
		'{OP_BYTE,   8'h40, 8'd35, 8'd1,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_BYTE,   8'h10, 8'd33, 8'd7,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_BYTE,   8'hC0, 8'd32, 8'd1,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		// third full-length token in a row: the longest batch, 26 chunks
		'{OP_BYTE,   8'h55, 8'd40, 8'd5,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		// partial token thrown away by a clear
		'{OP_BYTE,   8'h61, 8'd3,  8'd1,  1'b0, '0},
		'{OP_CLEAR,  8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b1, '{64'h0, 4'd0, 2'd1, 1'b1, 1'b1}},
		// a token that is the join mark itself
		'{OP_BYTE,   8'h25, 8'd1,  8'd0,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0},
		// a token of exactly one full chunk
		'{OP_BYTE,   8'h7F, 8'd8,  8'd16, 1'b0, '0},
		'{OP_END,    8'h00, 8'd1,  8'd0,  1'b0, '0}
	};

	int phase_idle  [4] = '{0, 46, 0, 32};
	int phase_stall [4] = '{0, 0, 46, 32};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Advance the predictor by one accepted beat; push the chunks it causes
	function automatic void shingle_step(logic [1:0] op, logic [7:0] b);
		logic [7:0]  joined [$];
		chunk_beat_t c;
		int unsigned slot;
		int unsigned pos;
		int unsigned take;
		int unsigned n;
		int unsigned i;
		int unsigned k;

		case (op)
			OP_BYTE: begin
				if (fill < MAX_BYTES) begin
					hist_bytes[slot_w][fill] = b;
					fill++;
				end
			end
			OP_CLEAR: begin
				// write slot stays where it is
				held = 0;
				fill = 0;
			end
			OP_END: begin
				hist_len[slot_w] = fill[5:0];
				fill = 0;
				slot_w = (slot_w + 1) % DEPTH;
				if (held < DEPTH)
					held++;
				for (n = 1; n <= held; n++) begin
					// join the newest n tokens, oldest first
					joined.delete();
					for (i = 0; i < n; i++) begin
						slot = (slot_w + 2 * DEPTH - n + i) % DEPTH;
						if (i > 0)
							joined.push_back(JOIN_MARK);
						for (k = 0; k < hist_len[slot]; k++)
							joined.push_back(hist_bytes[slot][k]);
					end
					// cut into chunks; an empty composite still gives one
					pos = 0;
					do begin
						take = joined.size() - pos;
						if (take > 8)
							take = 8;
						c = '0;
						for (k = 0; k < take; k++)
							c.chunk[8 * k +: 8] = joined[pos + k];
						pos += take;
						c.nbytes    = take[3:0];
						c.order     = n[1:0];
						c.comp_end  = (pos >= joined.size());
						c.batch_end = c.comp_end && (n == held);
						expected_chunks.push_back(c);
					end while (pos < joined.size());
				end
			end
			default: ;
		endcase
	endfunction

	// Drive one beat, hold it until taken, then predict. A pinned row swaps
	// the predicted chunks for the one typed in the script.
	task automatic send_beat(logic [1:0] op, logic [7:0] b, logic pin, chunk_beat_t pin_res);
		int unsigned base;

		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid     <= 1'b1;
		items_if.operation <= op;
		items_if.data_byte <= b;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		base = expected_chunks.size();
		shingle_step(op, b);
		if (pin) begin
			while (expected_chunks.size() > base)
				void'(expected_chunks.pop_back());
			expected_chunks.push_back(pin_res);
		end
	endtask

	// Random stream: mostly whole tokens, some clears, stray partial tokens
	// and ignored beats. Returns the beats that count toward the phase.
	task automatic send_random_burst(output int counted);
		int pick;
		int len;
		int r;

		counted = 0;
		pick = $urandom_range(99);
		if (pick < 4) begin
			send_beat(OP_UNUSED, 8'($urandom), 1'b0, '0);
		end else if (pick < 9) begin
			send_beat(OP_CLEAR, 8'($urandom), 1'b0, '0);
			counted = 1;
		end else if (pick < 15) begin
			// stray bytes; a later end or clear closes them
			len = $urandom_range(1, 4);
			for (r = 0; r < len; r++)
				send_beat(OP_BYTE, 8'($urandom), 1'b0, '0);
			counted = len;
		end else begin
			// now and then an overlong token, else a short one
			len = ($urandom_range(19) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 10);
			for (r = 0; r < len; r++)
				send_beat(OP_BYTE, 8'($urandom), 1'b0, '0);
			send_beat(OP_END, 8'($urandom), 1'b0, '0);
			counted = len + 1;
		end
	endtask

	// Output side: stall at the phase's rate
	always @(posedge clk)
		chunks_if.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			failures++;
		end
	endfunction

	// Compare every accepted chunk with the oldest expected one
	always @(posedge clk) begin : chunk_check
		chunk_beat_t want;

		if (arst_n && chunks_if.valid && chunks_if.ready) begin
			if (expected_chunks.size() == 0) begin
				$error("chunk: expected none, got %h (bytes %0d)",
					chunks_if.chunk, chunks_if.chunk_bytes);
				failures++;
			end else begin
				want = expected_chunks.pop_front();
				check_field("chunk", want.chunk, chunks_if.chunk);
				check_field("chunk_bytes", 64'(want.nbytes), 64'(chunks_if.chunk_bytes));
				check_field("gram_order", 64'(want.order), 64'(chunks_if.gram_order));
				check_field("composite_end", 64'(want.comp_end), 64'(chunks_if.composite_end));
				check_field("batch_end", 64'(want.batch_end), 64'(chunks_if.batch_end));
			end
		end
	end

	// Drop the run when neither side moves a beat for too long
	initial begin : watchdog
		int quiet;

		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((items_if.valid && items_if.ready) || (chunks_if.valid && chunks_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL token_ngram_composer_top");
		$finish;
	end

	initial begin : stimulus
		int row;
		int r;
		int ph;
		int counted;
		int got;

		arst_n             <= 1'b0;
		items_if.valid     <= 1'b0;
		items_if.operation <= OP_BYTE;
		items_if.data_byte <= 8'h00;
		slot_w = 0;
		held   = 0;
		fill   = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script, no idling on either side
		for (row = 0; row < $size(script); row++)
			for (r = 0; r < script[row].reps; r++)
				send_beat(script[row].op, script[row].data + 8'(r * script[row].step),
					script[row].pin, script[row].res);

		// Random part in phases of sender idling and receiver stalls
		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				send_random_burst(got);
				counted += got;
			end
		end

		// Drain: let all outstanding chunks arrive, then watch for strays
		items_if.valid <= 1'b0;
		stall_pct = 0;
		while (expected_chunks.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (failures == 0)
			$display("PASS token_ngram_composer_top");
		else
			$display("FAIL token_ngram_composer_top");
		$finish;
	end

endmodule
